FILE: src/laser_beam_ray_caster_defines.svh
// Assertion macros for the beam ray caster
`ifndef LASER_BEAM_RAY_CASTER_DEFINES_SVH
`define LASER_BEAM_RAY_CASTER_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define LBRC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LBRC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: src/lbrc_pkg.sv
// ----------------------------------------------------------------------------
// lbrc_pkg
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package lbrc_pkg;
  localparam int MAX_RANGE_CELLS_DEF = 63;
  localparam int BEAM_INDEX_BITS_DEF = 12;
  localparam int CORDIC_STEPS = 16;
  localparam logic [17:0] PHASE_MUL = 18'd166886;
  localparam logic [15:0] CORDIC_GAIN_INV = 16'd39797;
  localparam logic [15:0] CPM_RESET = 16'd1311;

  typedef enum logic [2:0] {
    CFG_BASE_ANGLE  = 3'd0,
    CFG_ANGLE_STEP  = 3'd1,
    CFG_THRESHOLD   = 3'd2,
    CFG_CELLS_PER_MM = 3'd3,
    CFG_MAX_RANGE   = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FS_IDLE, FS_MUL, FS_CORDIC, FS_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BS_IDLE, BS_OCC, BS_FREE
  } back_state_t;

  // endpoint job passed from front to back
  typedef struct packed {
    logic [6:0] x1;
    logic [6:0] y1;
  } job_t;

  function automatic logic signed [15:0] atan_lut(input logic [3:0] i);
    logic signed [15:0] v;
    case (i)
      4'd0: v = 16'sd8192;  4'd1: v = 16'sd4836;  4'd2: v = 16'sd2555;
      4'd3: v = 16'sd1297;  4'd4: v = 16'sd651;   4'd5: v = 16'sd326;
      4'd6: v = 16'sd163;   4'd7: v = 16'sd81;    4'd8: v = 16'sd41;
      4'd9: v = 16'sd20;    4'd10: v = 16'sd10;   4'd11: v = 16'sd5;
      4'd12: v = 16'sd3;    4'd13: v = 16'sd1;    4'd14: v = 16'sd1;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction
endpackage

FILE: src/laser_beam_ray_caster.sv
// ----------------------------------------------------------------------------
// laser_beam_ray_caster
// Lidar beam to occupancy grid cell ray caster.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one beam word: index, range, intensity.
// Beams below the intensity threshold are dropped in the accept cycle.
// The front computes the angle and range products and then runs a 16-iteration
// CORDIC, one rotation per cycle, and then places the endpoint; a beam holds
// the front until its endpoint is pushed or dropped. Endpoints go into a
// two-entry queue; an endpoint outside the grid is dropped and gives no word.
// The back walks the Bresenham line one cell per cycle while the output is not
// stalled: the occupied endpoint first, then up to 63 free cells; out_last
// marks the final word of a beam. The back pops a job only when idle, emits
// 1 to 64 words for it and takes another job only after the final word. A stall
// on the output holds the output register and the walk; the queue then fills
// and the front stalls the input in turn.
// Configuration is written through cfg_valid/cfg_ready; the user must write it
// only while idle, as the block itself does not enforce this.
// Reset (rst_n low, synchronous) empties the queue and restores register
// defaults.
// ----------------------------------------------------------------------------
`include "laser_beam_ray_caster_defines.svh"
module laser_beam_ray_caster #(
  parameter int MAX_RANGE_CELLS = lbrc_pkg::MAX_RANGE_CELLS_DEF,
  parameter int BEAM_INDEX_BITS = lbrc_pkg::BEAM_INDEX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_beam_index,
  input  logic [15:0] in_range_mm,
  input  logic [15:0] in_intensity,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_cell_x,
  output logic [6:0]  out_cell_y,
  output logic        out_occupied,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import lbrc_pkg::*;

  logic [15:0] base_angle_r, angle_step_r, threshold_r, cpm_r;
  logic [5:0]  max_range_r;
  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_angle_r <= '0; angle_step_r <= '0; threshold_r <= '0;
      cpm_r <= CPM_RESET; max_range_r <= 6'(MAX_RANGE_CELLS);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BASE_ANGLE:   base_angle_r <= cfg_data;
        CFG_ANGLE_STEP:   angle_step_r <= cfg_data;
        CFG_THRESHOLD:    threshold_r <= cfg_data;
        CFG_CELLS_PER_MM: cpm_r <= cfg_data;
        CFG_MAX_RANGE:
          max_range_r <= (cfg_data[5:0] > 6'(MAX_RANGE_CELLS)) ?
                         6'(MAX_RANGE_CELLS) : cfg_data[5:0];
        default: ;
      endcase
    end
  end

  logic push, full, pop, q_valid;
  job_t push_job, q_job;

  lbrc_front #(.BEAM_INDEX_BITS(BEAM_INDEX_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_beam_index, .in_range_mm, .in_intensity,
    .base_angle(base_angle_r), .angle_step(angle_step_r), .threshold(threshold_r),
    .cells_per_mm(cpm_r), .max_range(max_range_r), .push, .push_job, .q_full(full)
  );
  lbrc_queue u_queue (
    .clk, .rst_n, .push, .push_job, .full, .pop, .q_valid, .q_job
  );
  lbrc_back u_back (
    .clk, .rst_n, .q_valid, .q_job, .pop, .max_range(max_range_r),
    .out_valid, .out_stall, .out_cell_x, .out_cell_y, .out_occupied, .out_last
  );

  `LBRC_ASSERT_IMP(a_no_push_full, push, !full, "push into full queue")
  `LBRC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "stalled word dropped")
  `LBRC_ASSERT_IMP(a_pop_valid, pop, q_valid, "pop from empty queue")
endmodule

FILE: src/lbrc_front.sv
// ----------------------------------------------------------------------------
// lbrc_front
// Accepts beams, filters by intensity, computes the endpoint by CORDIC.
// ----------------------------------------------------------------------------
module lbrc_front #(
  parameter int BEAM_INDEX_BITS = lbrc_pkg::BEAM_INDEX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_beam_index,
  input  logic [15:0] in_range_mm,
  input  logic [15:0] in_intensity,
  input  logic [15:0] base_angle,
  input  logic [15:0] angle_step,
  input  logic [15:0] threshold,
  input  logic [15:0] cells_per_mm,
  input  logic [5:0]  max_range,
  output logic        push,
  output lbrc_pkg::job_t push_job,
  input  logic        q_full
);
  import lbrc_pkg::*;

  // only the low index bits take part in the angle
  localparam logic [11:0] IDX_MASK = 12'((1 << BEAM_INDEX_BITS) - 1);

  front_state_t st_r, st_nxt;
  logic [11:0] idx_r;
  logic [15:0] rmm_r;
  logic [1:0]  ph_step_r;
  logic signed [33:0] angle_r;
  logic [31:0] r_r;
  logic signed [24:0] vx_r, vy_r;
  logic signed [17:0] z_r;
  logic flip_r;
  logic [3:0] it_r;

  logic accept;
  logic signed [51:0] ph_prod;
  logic [15:0] ph;
  logic signed [24:0] dx, dy;
  logic signed [24:0] vxf, vyf;
  logic signed [8:0] tx, ty;
  logic signed [9:0] x1s, y1s;
  logic [47:0] gprod;
  logic [31:0] rc;
  logic [21:0] cmax;
  logic inb;

  assign in_stall = (st_r != FS_IDLE);
  assign accept = in_valid && !in_stall && (in_intensity >= threshold);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      FS_IDLE:   if (accept) st_nxt = FS_MUL;
      FS_MUL:    if (ph_step_r == 2'd2) st_nxt = FS_CORDIC;
      FS_CORDIC: if (it_r == 4'(CORDIC_STEPS - 1)) st_nxt = FS_PUSH;
      FS_PUSH:   if (!inb || !q_full) st_nxt = FS_IDLE;
      default:   st_nxt = FS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    push = (st_r == FS_PUSH) && inb && !q_full;
    push_job.x1 = x1s[6:0];
    push_job.y1 = y1s[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= FS_IDLE;
    else st_r <= st_nxt;
  end

  // datapath
  assign ph_prod = angle_r * $signed({1'b0, PHASE_MUL});
  assign ph = ph_prod[31:16];
  assign cmax = {max_range, 16'd0};
  assign rc = (r_r > {10'd0, cmax}) ?
              ((max_range == 6'd0) ? 32'd0 : {10'd0, max_range - 6'd1, 16'd0}) : r_r;
  assign gprod = rc * CORDIC_GAIN_INV;
  assign dx = vy_r >>> it_r;
  assign dy = vx_r >>> it_r;

  // truncate the final vector toward zero and place it around the centre
  assign vxf = flip_r ? -vx_r : vx_r;
  assign vyf = flip_r ? -vy_r : vy_r;
  assign tx = vxf[24] ? -9'(($unsigned(-vxf)) >> 16) : 9'(vxf >>> 16);
  assign ty = vyf[24] ? -9'(($unsigned(-vyf)) >> 16) : 9'(vyf >>> 16);
  assign x1s = $signed({4'd0, max_range}) + 10'(tx);
  assign y1s = $signed({4'd0, max_range}) + 10'(ty);

  // drop endpoints outside 0..2*max_range
  assign inb = !x1s[9] && !y1s[9] && (x1s <= $signed({3'd0, max_range, 1'b0})) &&
               (y1s <= $signed({3'd0, max_range, 1'b0}));

  always_ff @(posedge clk) begin
    case (st_r)
      FS_IDLE: if (accept) begin
        idx_r <= in_beam_index & IDX_MASK;
        rmm_r <= in_range_mm;
        ph_step_r <= 2'd0;
      end
      FS_MUL: begin
        ph_step_r <= ph_step_r + 2'd1;
        if (ph_step_r == 2'd0) begin
          angle_r <= 34'($signed(base_angle)) +
                     $signed({1'b0, idx_r}) * $signed(angle_step);
          r_r <= rmm_r * cells_per_mm;
        end else if (ph_step_r == 2'd1) begin
          vx_r <= $signed({1'b0, gprod[39:16]});
          vy_r <= '0;
          it_r <= '0;
        end else begin
          if (ph >= 16'd16384 && ph < 16'd49152) begin
            flip_r <= 1'b1;
            z_r <= $signed({2'b0, ph}) - 18'sd32768;
          end else begin
            flip_r <= 1'b0;
            z_r <= ph[15] ? $signed({2'b0, ph}) - 18'sd65536 : $signed({2'b0, ph});
          end
        end
      end
      FS_CORDIC: begin
        it_r <= it_r + 4'd1;
        if (!z_r[17]) begin
          vx_r <= vx_r - dx; vy_r <= vy_r + dy; z_r <= z_r - 18'(atan_lut(it_r));
        end else begin
          vx_r <= vx_r + dx; vy_r <= vy_r - dy; z_r <= z_r + 18'(atan_lut(it_r));
        end
      end
      FS_PUSH: ;
      default: ;
    endcase
  end
endmodule

FILE: src/lbrc_back.sv
// ----------------------------------------------------------------------------
// lbrc_back
// Walks the Bresenham line from the centre and emits cells.
// ----------------------------------------------------------------------------
module lbrc_back (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  lbrc_pkg::job_t q_job,
  output logic        pop,
  input  logic [5:0]  max_range,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_cell_x,
  output logic [6:0]  out_cell_y,
  output logic        out_occupied,
  output logic        out_last
);
  import lbrc_pkg::*;

  back_state_t st_r, st_nxt;
  logic [6:0] x1_r, y1_r, x0_r, y0_r;
  logic signed [8:0] ddx_r, ddy_r, err_r;
  logic sx_r, sy_r;
  logic [6:0] n_r;
  logic ov_r;
  logic [6:0] ox_r, oy_r;
  logic oocc_r, olast_r;

  logic free_ok, sink, at_end, nx_end;
  logic signed [9:0] e2;
  logic [6:0] xn, yn;
  logic signed [8:0] errn;
  assign sink = !ov_r || !out_stall;
  assign at_end = (x0_r == x1_r) && (y0_r == y1_r);
  assign e2 = {err_r, 1'b0};
  always_comb begin
    xn = x0_r; yn = y0_r; errn = err_r;
    if (e2 >= 10'(ddy_r)) begin
      errn = errn + ddy_r; xn = sx_r ? x0_r + 7'd1 : x0_r - 7'd1;
    end
    if (e2 <= 10'(ddx_r)) begin
      errn = errn + ddx_r; yn = sy_r ? y0_r + 7'd1 : y0_r - 7'd1;
    end
  end
  assign nx_end = ((xn == x1_r) && (yn == y1_r)) || (n_r == 7'd63);
  assign free_ok = sink;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BS_IDLE: if (q_valid) st_nxt = BS_OCC;
      BS_OCC:  if (sink) st_nxt = at_end ? BS_IDLE : BS_FREE;
      BS_FREE: if (free_ok && nx_end) st_nxt = BS_IDLE;
      default: st_nxt = BS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop = (st_r == BS_IDLE) && q_valid;
    out_valid = ov_r;
    out_cell_x = ox_r;
    out_cell_y = oy_r;
    out_occupied = oocc_r;
    out_last = olast_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BS_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (sink) ov_r <= (st_r == BS_OCC) || (st_r == BS_FREE);
    end
  end

  logic [6:0] c7;
  assign c7 = {1'b0, max_range};
  always_ff @(posedge clk) begin
    if (st_r == BS_IDLE && q_valid) begin
      x1_r <= q_job.x1; y1_r <= q_job.y1;
      x0_r <= c7; y0_r <= c7;
      sx_r <= c7 < q_job.x1; sy_r <= c7 < q_job.y1;
      ddx_r <= (q_job.x1 > c7) ? 9'(q_job.x1 - c7) : 9'(c7 - q_job.x1);
      ddy_r <= (q_job.y1 > c7) ? -9'(q_job.y1 - c7) : -9'(c7 - q_job.y1);
      err_r <= ((q_job.x1 > c7) ? 9'(q_job.x1 - c7) : 9'(c7 - q_job.x1)) -
               ((q_job.y1 > c7) ? 9'(q_job.y1 - c7) : 9'(c7 - q_job.y1));
      n_r <= 7'd1;
    end
    if (st_r == BS_OCC && sink) begin
      ox_r <= x1_r; oy_r <= y1_r; oocc_r <= 1'b1; olast_r <= at_end;
    end
    if (st_r == BS_FREE && sink) begin
      ox_r <= x0_r; oy_r <= y0_r; oocc_r <= 1'b0; olast_r <= nx_end;
      x0_r <= xn; y0_r <= yn; err_r <= errn; n_r <= n_r + 7'd1;
    end
  end
endmodule

FILE: src/lbrc_queue.sv
// ----------------------------------------------------------------------------
// lbrc_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module lbrc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lbrc_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output lbrc_pkg::job_t q_job
);
  import lbrc_pkg::*;

  job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  assign full = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_job = mem_r[rp_r];

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end
endmodule
